[hw/rtl/ratnorm_pkg.sv]
package ratnorm_pkg;

    // default operand width of the normaliser
    localparam int DEFAULT_DATA_WIDTH = 32;

    // status of the shared divider, seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hw/rtl/ratnorm_divider.sv]
module ratnorm_divider #(
    parameter int DATA_WIDTH = ratnorm_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output ratnorm_pkg::div_stat_t stat,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);
    import ratnorm_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] q_reg;
    logic [DATA_WIDTH-1:0] r_reg;
    logic [DATA_WIDTH-1:0] d_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;
    logic [DATA_WIDTH-1:0] r_next;
    logic [DATA_WIDTH-1:0] q_next;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {r_reg, q_reg[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = ~diff[DATA_WIDTH];
        r_next  = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        q_next  = {q_reg[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && cnt_reg == '0)
            begin
                q_reg   <= dividend;
                r_reg   <= '0;
                d_reg   <= divisor;
                cnt_reg <= CNT_W'(DATA_WIDTH);
            end
            else if (cnt_reg != '0)
            begin
                q_reg    <= q_next;
                r_reg    <= r_next;
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

[hw/rtl/rational_normalizer_core.sv]
// rational_normalizer_core: reduces a signed fraction num_in/den_in to lowest terms
//
// request channel: req_valid/req_ready carry num_in and den_in; a request is
// taken when both are high. one request is worked on at a time, and
// req_ready stays low from acceptance until the result has been handed to
// the output register
// response channel: rsp_valid/rsp_ready carry num_out, den_out and
// div_by_zero. the output register holds a finished result while the
// receiver stalls, and the next request may be accepted meanwhile
// a zero numerator or zero denominator skips the euclid and division steps
// and goes from idle to the finish state. any other request runs the euclid
// remainder steps and then the two divisions by the gcd on the bit-serial
// divider, one quotient bit per cycle, which is shared by every remainder
// step and by the two final divisions by the gcd
// a zero denominator gives 0/1 with div_by_zero set; the sign of the fraction
// always ends up on the numerator and den_out is at least 1
// reset: asynchronous, active low; the sequencer returns to idle and any
// pending result is dropped
module rational_normalizer_core #(
    parameter int DATA_WIDTH = ratnorm_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic signed [DATA_WIDTH-1:0] num_in,
    input  logic signed [DATA_WIDTH-1:0] den_in,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic signed [DATA_WIDTH-1:0] num_out,
    output logic        [DATA_WIDTH-2:0] den_out,
    output logic                         div_by_zero
);
    import ratnorm_pkg::*;

    // largest magnitude that fits the signed output
    localparam logic [DATA_WIDTH-1:0] MAG_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WAIT,
        S_DIVN,
        S_DIVN_WAIT,
        S_DIVD,
        S_DIVD_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;

    // euclid operands; x_reg ends up holding the gcd
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic                  sel_x_reg;
    // input magnitudes and reduced magnitudes
    logic [DATA_WIDTH-1:0] nm_reg;
    logic [DATA_WIDTH-1:0] dm_reg;
    logic [DATA_WIDTH-1:0] rn_reg;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic                  neg_reg;
    logic                  dbz_reg;

    // output register
    logic                         rsp_valid_reg;
    logic signed [DATA_WIDTH-1:0] num_out_reg;
    logic        [DATA_WIDTH-2:0] den_out_reg;
    logic                         dbz_out_reg;

    // shared divider
    logic                  div_start;
    logic [DATA_WIDTH-1:0] div_dividend;
    logic [DATA_WIDTH-1:0] div_divisor;
    div_stat_t             div_stat;
    logic [DATA_WIDTH-1:0] div_quot;
    logic [DATA_WIDTH-1:0] div_rem;

    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic                  x_gt_y;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] rn_sat;
    logic [DATA_WIDTH-1:0] rd_sat;

    // magnitudes; the most negative value maps onto 2^(DATA_WIDTH-1) exactly
    assign num_mag = num_in[DATA_WIDTH-1] ? (~num_in + 1'b1) : num_in;
    assign den_mag = den_in[DATA_WIDTH-1] ? (~den_in + 1'b1) : den_in;

    assign x_gt_y   = (x_reg > y_reg);
    assign out_free = ~rsp_valid_reg | rsp_ready;

    // only a most negative input can push a reduced magnitude over the limit
    assign rn_sat = (rn_reg > MAG_MAX) ? MAG_MAX : rn_reg;
    assign rd_sat = (rd_reg > MAG_MAX) ? MAG_MAX : rd_reg;

    // divider operand select: larger mod smaller during euclid, then the
    // two magnitudes divided by the gcd
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = nm_reg;
        div_divisor  = x_reg;
        unique case (state_reg)
            S_GCD:
            begin
                div_start    = (x_reg != '0) && (y_reg != '0) && !div_stat.busy;
                div_dividend = x_gt_y ? x_reg : y_reg;
                div_divisor  = x_gt_y ? y_reg : x_reg;
            end
            S_DIVN:
            begin
                div_start    = !div_stat.busy;
                div_dividend = nm_reg;
            end
            S_DIVD:
            begin
                div_start    = !div_stat.busy;
                div_dividend = dm_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ratnorm_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            sel_x_reg     <= 1'b0;
            nm_reg        <= '0;
            dm_reg        <= '0;
            rn_reg        <= '0;
            rd_reg        <= '0;
            neg_reg       <= 1'b0;
            dbz_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            num_out_reg   <= '0;
            den_out_reg   <= '0;
            dbz_out_reg   <= 1'b0;
        end
        else
        begin
            // response taken by the receiver, unless a new result replaces it
            if (rsp_valid_reg && rsp_ready && state_reg != S_FINISH)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        nm_reg  <= num_mag;
                        dm_reg  <= den_mag;
                        x_reg   <= num_mag;
                        y_reg   <= den_mag;
                        priority if (den_in == '0)
                        begin
                            // division by zero: 0/1 with the flag
                            rn_reg    <= '0;
                            rd_reg    <= DATA_WIDTH'(1);
                            neg_reg   <= 1'b0;
                            dbz_reg   <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                        else if (num_in == '0)
                        begin
                            rn_reg    <= '0;
                            rd_reg    <= DATA_WIDTH'(1);
                            neg_reg   <= 1'b0;
                            dbz_reg   <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            neg_reg   <= num_in[DATA_WIDTH-1] ^ den_in[DATA_WIDTH-1];
                            dbz_reg   <= 1'b0;
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_GCD:
                begin
                    if (x_reg == '0 || y_reg == '0)
                    begin
                        // one operand has run out, the other is the gcd
                        x_reg     <= x_reg | y_reg;
                        state_reg <= S_DIVN;
                    end
                    else if (div_start)
                    begin
                        sel_x_reg <= x_gt_y;
                        state_reg <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        if (sel_x_reg)
                        begin
                            x_reg <= div_rem;
                        end
                        else
                        begin
                            y_reg <= div_rem;
                        end
                        state_reg <= S_GCD;
                    end
                end
                S_DIVN:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIVN_WAIT;
                    end
                end
                S_DIVN_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        rn_reg    <= div_quot;
                        state_reg <= S_DIVD;
                    end
                end
                S_DIVD:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIVD_WAIT;
                    end
                end
                S_DIVD_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        rd_reg    <= div_quot;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // hand over once the output register is free
                    if (out_free)
                    begin
                        num_out_reg   <= neg_reg ? (~rn_sat + 1'b1) : rn_sat;
                        den_out_reg   <= rd_sat[DATA_WIDTH-2:0];
                        dbz_out_reg   <= dbz_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign num_out     = num_out_reg;
    assign den_out     = den_out_reg;
    assign div_by_zero = dbz_out_reg;

endmodule

[hw/rtl/ratnorm_checker.sv]
module ratnorm_checker #(
    parameter int DATA_WIDTH = ratnorm_pkg::DEFAULT_DATA_WIDTH
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic signed [DATA_WIDTH-1:0] num_in,
    input logic signed [DATA_WIDTH-1:0] den_in,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic signed [DATA_WIDTH-1:0] num_out,
    input logic        [DATA_WIDTH-2:0] den_out,
    input logic                         div_by_zero
);
    import ratnorm_pkg::*;

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(num_out)
            && $stable(den_out) && $stable(div_by_zero))
        else $error("response changed while stalled");

    // after a request is taken, req_ready is low in the following cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // a zero denominator always yields 0/1
    a_dbz_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && div_by_zero |-> num_out == '0 && den_out == (DATA_WIDTH-1)'(1))
        else $error("division by zero result is not 0/1");

    // the denominator is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> den_out != '0)
        else $error("zero denominator in response");

    // a zero numerator comes out in lowest terms as 0/1
    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && num_out == '0 |-> den_out == (DATA_WIDTH-1)'(1))
        else $error("zero numerator not reduced to 0/1");

endmodule

bind rational_normalizer_core ratnorm_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_ratnorm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .num_in      (num_in),
    .den_in      (den_in),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .num_out     (num_out),
    .den_out     (den_out),
    .div_by_zero (div_by_zero)
);

[dv/tb_rational_normalizer_core.sv]
// expected reduced fractions, worked out on each accepted request and
// compared in order with the responses
class fraction_scoreboard;

    localparam int DW = ratnorm_pkg::DEFAULT_DATA_WIDTH;

    typedef struct packed {
        logic signed [DW-1:0] num;
        logic        [DW-2:0] den;
        logic                 div_by_zero;
    } fraction_t;

    fraction_t   pending_fractions[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned zero_dens;
    int unsigned zero_nums;

    function new();
        mismatches = 0;
        checked    = 0;
        zero_dens  = 0;
        zero_nums  = 0;
    endfunction

    // lowest terms via euclid on the magnitudes, sign moved to the numerator
    function fraction_t reduce_fraction(logic [DW-1:0] n, logic [DW-1:0] d);
        fraction_t       r;
        logic [DW-1:0]   n_abs;
        logic [DW-1:0]   d_abs;
        logic [DW-1:0]   mag_w;
        longint unsigned x;
        longint unsigned y;
        longint unsigned g;
        longint unsigned rn;
        longint unsigned rd;
        longint unsigned mag_max;
        logic            neg;
        r.num         = '0;
        r.den         = 1;
        r.div_by_zero = 1'b0;
        if (d == '0) begin
            r.div_by_zero = 1'b1;
            return r;
        end
        if (n == '0)
            return r;
        n_abs = n[DW-1] ? -n : n;
        d_abs = d[DW-1] ? -d : d;
        neg   = n[DW-1] ^ d[DW-1];
        x = n_abs;
        y = d_abs;
        while (x != 0 && y != 0) begin
            if (x > y)
                x = x % y;
            else
                y = y % x;
        end
        g = x + y;
        rn = longint'(n_abs) / g;
        rd = longint'(d_abs) / g;
        mag_max = (64'd1 << (DW - 1)) - 1;
        if (rn > mag_max)
            rn = mag_max;
        if (rd > mag_max)
            rd = mag_max;
        mag_w = rn[DW-1:0];
        r.num = neg ? -mag_w : mag_w;
        r.den = rd[DW-2:0];
        return r;
    endfunction

    function void note_request(logic [DW-1:0] n, logic [DW-1:0] d);
        if (d == '0)
            zero_dens++;
        else if (n == '0)
            zero_nums++;
        pending_fractions.push_back(reduce_fraction(n, d));
    endfunction

    function void check_response(logic signed [DW-1:0] num, logic [DW-2:0] den,
                                 logic dz, realtime at);
        fraction_t exp_f;
        if (pending_fractions.size() == 0) begin
            $display("%0t: unexpected response %0d/%0d dz=%0b", at, num, den, dz);
            mismatches++;
            return;
        end
        exp_f = pending_fractions.pop_front();
        checked++;
        if (num !== exp_f.num) begin
            $display("%0t: num_out expected %0d actual %0d", at, exp_f.num, num);
            mismatches++;
        end
        if (den !== exp_f.den) begin
            $display("%0t: den_out expected %0d actual %0d", at, exp_f.den, den);
            mismatches++;
        end
        if (dz !== exp_f.div_by_zero) begin
            $display("%0t: div_by_zero expected %0b actual %0b", at,
                     exp_f.div_by_zero, dz);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return pending_fractions.size();
    endfunction

endclass

module tb_rational_normalizer_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DW          = ratnorm_pkg::DEFAULT_DATA_WIDTH;
    localparam int          RAND_ITEMS  = 1030;
    localparam int          QUIET_ITEMS = 120;     // tail of the run with no idling
    localparam int          HOLD_CYCLES = 4000;    // long receiver hold-off
    localparam int          HOLD_AFTER  = 200;     // requests before the hold-off
    localparam int          DRAIN       = 1800;    // beyond the worst-case latency
    localparam longint      LIMIT       = 6500000;
    localparam logic [DW-1:0] MAX_POS   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic signed [DW-1:0] num_in = '0;
    logic signed [DW-1:0] den_in = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic signed [DW-1:0] num_out;
    logic        [DW-2:0] den_out;
    logic                 div_by_zero;

    fraction_scoreboard   sb;
    int unsigned          sent_count = 0;
    int unsigned          directed_count = 0;
    int unsigned          stall_cycles = 0;
    longint               cycle_count = 0;
    bit                   quiet_tail = 1'b0;
    bit                   hold_done = 1'b0;
    int unsigned          fib[0:46];

    rational_normalizer_core #(
        .DATA_WIDTH (DW)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .num_in      (num_in),
        .den_in      (den_in),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .num_out     (num_out),
        .den_out     (den_out),
        .div_by_zero (div_by_zero)
    );

    always #4 clk = ~clk;

    // idling percentage for the current stretch: every fourth block of 64
    // requests runs flat out, and so does the tail of the run
    function automatic int idle_rate();
        if (quiet_tail || ((sent_count / 64) % 4) == 3)
            return 0;
        return 25;
    endfunction

    // any operand in the legal range, the most negative value left out
    function automatic logic [DW-1:0] any_operand();
        logic [DW-1:0] v;
        do
            v = $urandom;
        while (v == MOST_NEG);
        return v;
    endfunction

    function automatic logic [DW-1:0] with_sign(logic [DW-1:0] mag, bit neg);
        return neg ? -mag : mag;
    endfunction

    // offer one request and hold it until taken; valid stays up afterwards
    // so that a back-to-back request leaves no gap in valid
    task automatic send_fraction(logic [DW-1:0] n, logic [DW-1:0] d);
        req_valid <= 1'b1;
        num_in    <= n;
        den_in    <= d;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(n, d);
        sent_count++;
    endtask

    // random gap on the request side, taken only between requests
    task automatic maybe_pause_requests();
        if ($urandom_range(0, 99) < idle_rate()) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // random request: wide noise, fractions with shared factors, small values,
    // long euclid chains, powers of two, field extremes and the zero cases
    task automatic random_fraction();
        int unsigned   sel;
        int unsigned   i;
        logic [DW-1:0] g;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            send_fraction(any_operand(), any_operand());
        end else if (sel < 60) begin
            g = $urandom_range(1, 65535);
            a = $urandom_range(0, 32767);
            b = $urandom_range(1, 32767);
            send_fraction(with_sign(a * g, $urandom_range(0, 1)),
                          with_sign(b * g, $urandom_range(0, 1)));
        end else if (sel < 75) begin
            a = $urandom_range(0, 100);
            b = $urandom_range(0, 100);
            send_fraction(with_sign(a, $urandom_range(0, 1)),
                          with_sign(b, $urandom_range(0, 1)));
        end else if (sel < 80) begin
            send_fraction(any_operand(), '0);
        end else if (sel < 85) begin
            send_fraction('0, any_operand());
        end else if (sel < 93) begin
            // consecutive fibonacci numbers give the longest remainder chains
            i = $urandom_range(1, 45);
            if ($urandom_range(0, 1))
                send_fraction(with_sign(fib[i+1], $urandom_range(0, 1)),
                              with_sign(fib[i], $urandom_range(0, 1)));
            else
                send_fraction(with_sign(fib[i], $urandom_range(0, 1)),
                              with_sign(fib[i+1], $urandom_range(0, 1)));
        end else if (sel < 97) begin
            a = 1 << $urandom_range(0, DW - 2);
            b = 1 << $urandom_range(0, DW - 2);
            send_fraction(with_sign(a, $urandom_range(0, 1)),
                          with_sign(b, $urandom_range(0, 1)));
        end else begin
            send_fraction(with_sign(MAX_POS, $urandom_range(0, 1)),
                          $urandom_range(0, 1) ? with_sign(MAX_POS, 1'b1) : any_operand());
        end
    endtask

    // response side: random stall bursts, one long hold-off once HOLD_AFTER
    // requests have been sent so that the output register fills and req_ready drops
    initial begin
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                rsp_ready <= 1'b0;
            end else if (!hold_done && sent_count >= HOLD_AFTER) begin
                rsp_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                hold_done = 1'b1;
                rsp_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_rate() / 5) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                rsp_ready <= 1'b1;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // response monitor, sampled at the edge so the handshake is seen as
    // the block saw it
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(num_out, den_out, div_by_zero, $realtime);
        if (rst_n && req_valid && !req_ready)
            stall_cycles++;
    end

    // watchdog on a plain cycle counter
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, sb.outstanding());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb = new();
        fib[0] = 0;
        fib[1] = 1;
        for (int k = 2; k <= 46; k++)
            fib[k] = fib[k-1] + fib[k-2];

        // reset held low at the start, then released on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero denominator whatever the numerator
        send_fraction('0, '0);
        send_fraction(17, '0);
        send_fraction(with_sign(MAX_POS, 1'b1), '0);
        // zero numerator with a nonzero denominator of either sign
        send_fraction('0, 5);
        send_fraction('0, with_sign(MAX_POS, 1'b1));
        // field extremes and sign handling
        send_fraction(MAX_POS, MAX_POS);
        send_fraction(with_sign(MAX_POS, 1'b1), MAX_POS);
        send_fraction(MAX_POS, with_sign(1, 1'b1));
        send_fraction(1, MAX_POS);
        send_fraction(with_sign(1, 1'b1), with_sign(1, 1'b1));
        send_fraction(MAX_POS, MAX_POS - 1);
        send_fraction(MAX_POS - 1, MAX_POS >> 1);
        send_fraction(1, 1);
        send_fraction(7, 7);
        send_fraction(6, with_sign(4, 1'b1));
        send_fraction(with_sign(12, 1'b1), with_sign(18, 1'b1));
        send_fraction(1024, with_sign(65536, 1'b1));
        // longest euclid chain within range
        send_fraction(fib[46], fib[45]);
        send_fraction(with_sign(fib[45], 1'b1), fib[44]);
        // alternating bit patterns on both operands, then a pair of split half-word masks
        send_fraction(32'h5555_5555, 32'h2AAA_AAAA);
        send_fraction(32'hAAAA_AAAA, 32'hD555_5555);
        send_fraction(32'h7FFF_0000, 32'h0000_FFFF);
        directed_count = sent_count;

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            maybe_pause_requests();
            random_fraction();
        end
        req_valid <= 1'b0;

        // drain: every expected response, then one worst-case latency more
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d requests (%0d directed), %0d zero denominators, %0d zero numerators",
                 sent_count, directed_count, sb.zero_dens, sb.zero_nums);
        $display("request side stalled for %0d cycles, incl. a %0d-cycle receiver hold-off",
                 stall_cycles, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
